### rtl/core/cdg_pkg.sv
// Shared widths, register indexes and the line buffer data type for the gradient block.
package cdg_pkg;

    localparam int PIX_W     = 8;
    localparam int GRAD_W    = 9;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam int CFG_SIZE_RESET = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Registered read data of the two line buffers.
    typedef struct packed {
        logic [PIX_W-1:0] above;   // previous row, this column
        logic [PIX_W-1:0] right;   // previous row, next column
        logic [PIX_W-1:0] upper2;  // row before previous, this column
    } lb_data_t;

endpackage

### rtl/core/central_difference_gradient.sv
// Streaming 3x3 central-difference gradient over 8-bit raster pixels.
// Each pixel's results pass the item register, then the output register.
// Throughput: one pixel per cycle while out_stall is low; on the last row each pixel
// below the first row makes two results, sent one after the other by the single output register.
// Reset: position counters clear, image size returns to 1024 (clamped to the maximum);
// line buffers are not cleared, their stale contents never reach a reported gradient.
module central_difference_gradient #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [cdg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cdg_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [cdg_pkg::PIX_W-1:0]          pixel,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [cdg_pkg::GRAD_W-1:0]  grad_horizontal,
    output logic signed [cdg_pkg::GRAD_W-1:0]  grad_vertical,
    output logic                               last_in_run,
    output logic                               end_of_image
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // Compare widths wide enough for both the register and the maximum size.
    localparam int WCW = ($clog2(MAX_WIDTH + 1) > cdg_pkg::CFG_W) ?
                         $clog2(MAX_WIDTH + 1) : cdg_pkg::CFG_W;
    localparam int HCW = ($clog2(MAX_HEIGHT + 1) > cdg_pkg::CFG_W) ?
                         $clog2(MAX_HEIGHT + 1) : cdg_pkg::CFG_W;

    localparam int RST_W = (cdg_pkg::CFG_SIZE_RESET > MAX_WIDTH) ?
                           MAX_WIDTH : cdg_pkg::CFG_SIZE_RESET;
    localparam int RST_H = (cdg_pkg::CFG_SIZE_RESET > MAX_HEIGHT) ?
                           MAX_HEIGHT : cdg_pkg::CFG_SIZE_RESET;

    // ------------------------------------------------------------------
    // Configuration: hold the clamped size as "last column" / "last row".
    // ------------------------------------------------------------------
    logic [CW-1:0]  w_last_reg, w_last_next;
    logic [RW-1:0]  h_last_reg, h_last_next;
    logic [WCW-1:0] cfg_w_ext;
    logic [HCW-1:0] cfg_h_ext;

    always_comb
    begin
        cfg_w_ext = WCW'(cfg_data);
        cfg_h_ext = HCW'(cfg_data);

        if (cfg_data == '0)
        begin
            w_last_next = '0;
        end
        else if (cfg_w_ext > WCW'(MAX_WIDTH))
        begin
            w_last_next = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last_next = CW'(cfg_w_ext - 1'b1);
        end

        if (cfg_data == '0)
        begin
            h_last_next = '0;
        end
        else if (cfg_h_ext > HCW'(MAX_HEIGHT))
        begin
            h_last_next = RW'(MAX_HEIGHT - 1);
        end
        else
        begin
            h_last_next = RW'(cfg_h_ext - 1'b1);
        end
    end

    // ------------------------------------------------------------------
    // Input side: position counters and line buffer access.
    // ------------------------------------------------------------------
    logic          in_xfer;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_right;
    logic          end_row;
    logic          last_row;

    assign in_xfer   = in_valid && !in_stall;
    assign end_row   = (col_reg == w_last_reg);
    assign last_row  = (row_reg == h_last_reg);
    assign col_right = (col_reg == CW'(MAX_WIDTH - 1)) ? '0 : CW'(col_reg + 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg <= CW'(RST_W - 1);
            h_last_reg <= RW'(RST_H - 1);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_we)
        begin
            // Any register write restarts the image.
            if (cfg_index == cdg_pkg::REG_IMAGE_WIDTH)
            begin
                w_last_reg <= w_last_next;
            end
            if (cfg_index == cdg_pkg::REG_IMAGE_HEIGHT)
            begin
                h_last_reg <= h_last_next;
            end
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_xfer)
        begin
            if (end_row)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : RW'(row_reg + 1'b1);
            end
            else
            begin
                col_reg <= CW'(col_reg + 1'b1);
            end
        end
    end

    cdg_pkg::lb_data_t lb_data;

    cdg_linebuf #(
        .DEPTH (MAX_WIDTH)
    ) u_linebuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_xfer),
        .col       (col_reg),
        .col_right (col_right),
        .pixel     (pixel),
        .rd_data   (lb_data)
    );

    // ------------------------------------------------------------------
    // Item register. need_a: gradient result of the pixel above.
    // need_b: zero result of a bottom-row pixel itself.
    // ------------------------------------------------------------------
    logic                      need_a_reg;
    logic                      need_b_reg;
    logic                      interior_reg;
    logic                      eoi_reg;
    logic [cdg_pkg::PIX_W-1:0] px_reg;
    logic [cdg_pkg::PIX_W-1:0] left_reg;
    logic                      item_busy;
    logic                      out_load;
    logic                      item_done;

    assign item_busy = need_a_reg || need_b_reg;
    assign out_load  = item_busy && (!out_valid || !out_stall);
    // Release the item on its final result, or at once if it makes none.
    assign item_done = !item_busy || (out_load && !(need_a_reg && need_b_reg));
    assign in_stall  = !item_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_a_reg <= 1'b0;
            need_b_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            need_a_reg <= (row_reg != '0);
            need_b_reg <= last_row;
        end
        else if (out_load)
        begin
            // Drop the result just sent; the zero result always goes last.
            if (need_a_reg)
            begin
                need_a_reg <= 1'b0;
            end
            else
            begin
                need_b_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            px_reg       <= pixel;
            // Previous pixel's read of the previous row is now the left neighbor.
            left_reg     <= lb_data.above;
            eoi_reg      <= end_row && last_row;
            interior_reg <= (col_reg != '0) && (col_reg < w_last_reg)
                            && (row_reg > RW'(1));
        end
    end

    // ------------------------------------------------------------------
    // Differences and output register.
    // ------------------------------------------------------------------
    logic signed [cdg_pkg::GRAD_W-1:0] gh_diff;
    logic signed [cdg_pkg::GRAD_W-1:0] gv_diff;

    assign gh_diff = $signed({1'b0, lb_data.right}) - $signed({1'b0, left_reg});
    assign gv_diff = $signed({1'b0, px_reg}) - $signed({1'b0, lb_data.upper2});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (need_a_reg)
            begin
                grad_horizontal <= interior_reg ? gh_diff : '0;
                grad_vertical   <= interior_reg ? gv_diff : '0;
                last_in_run     <= !need_b_reg;
                end_of_image    <= 1'b0;
            end
            else
            begin
                grad_horizontal <= '0;
                grad_vertical   <= '0;
                last_in_run     <= 1'b1;
                end_of_image    <= eoi_reg;
            end
        end
    end

endmodule

### rtl/core/cdg_linebuf.sv
// Two line buffers: previous row and row before previous, with registered reads.
module cdg_linebuf #(
    parameter int DEPTH = 1024,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [IDX_W-1:0]          col,
    input  logic [IDX_W-1:0]          col_right,
    input  logic [cdg_pkg::PIX_W-1:0] pixel,
    output cdg_pkg::lb_data_t         rd_data
);

    logic [cdg_pkg::PIX_W-1:0] prev_mem [DEPTH];
    logic [cdg_pkg::PIX_W-1:0] prev2_mem [DEPTH];

    logic             mv_en_reg;
    logic [IDX_W-1:0] mv_col_reg;

    // Previous row: write the new pixel, read this and the next column; also read the row before previous.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            prev_mem[col]    <= pixel;
            rd_data.above    <= prev_mem[col];
            rd_data.right    <= prev_mem[col_right];
            rd_data.upper2   <= prev2_mem[col];
        end
    end

    // Move the old previous-row entry down in the cycle after its read.
    always_ff @(posedge clk)
    begin
        if (mv_en_reg)
        begin
            prev2_mem[mv_col_reg] <= rd_data.above;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_en_reg <= 1'b0;
        end
        else
        begin
            mv_en_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mv_col_reg <= col;
        end
    end

endmodule

### bench/tb_central_difference_gradient.sv
// Self-checking testbench for the streaming central-difference gradient block.
module tb_central_difference_gradient;

    localparam int MAX_SIZE     = 1024;
    localparam int RANDOM_ITEMS = 420;
    localparam int SETTLE       = 4;       // cycles after the last result before a write
    localparam int HOLD_CYCLES  = 300;     // long receiver hold-off in the pressure test
    localparam int LIMIT        = 40_000_000;

    // Directed 3x3 images whose center pixel hits both gradient extremes.
    // Rising: horizontal 255 - 0, vertical 0 - 255.
    localparam logic [cdg_pkg::PIX_W-1:0] RISING_3X3 [9] = '{
        8'd10,  8'd255, 8'd20,
        8'd0,   8'd77,  8'd255,
        8'd30,  8'd0,   8'd40
    };
    // Falling: horizontal 0 - 255, vertical 255 - 0.
    localparam logic [cdg_pkg::PIX_W-1:0] FALLING_3X3 [9] = '{
        8'd200, 8'd0,   8'd5,
        8'd255, 8'd128, 8'd0,
        8'd1,   8'd255, 8'd254
    };

    typedef enum int {
        FLOW_FREE,
        FLOW_SENDER_IDLE,
        FLOW_RECEIVER_STALL,
        FLOW_BOTH
    } flow_mode_t;

    typedef struct packed {
        logic signed [cdg_pkg::GRAD_W-1:0] horizontal;
        logic signed [cdg_pkg::GRAD_W-1:0] vertical;
        logic                              last;
        logic                              eoi;
    } gradient_t;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              cfg_we    = 1'b0;
    logic [cdg_pkg::CFG_IDX_W-1:0]     cfg_index = cdg_pkg::REG_IMAGE_WIDTH;
    logic [cdg_pkg::CFG_W-1:0]         cfg_data  = '0;
    logic                              in_valid  = 1'b0;
    logic                              in_stall;
    logic [cdg_pkg::PIX_W-1:0]         pixel     = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic signed [cdg_pkg::GRAD_W-1:0] grad_horizontal;
    logic signed [cdg_pkg::GRAD_W-1:0] grad_vertical;
    logic                              last_in_run;
    logic                              end_of_image;

    // Predictor copy of the block state: two line buffers, position and image size.
    bit [cdg_pkg::PIX_W-1:0]   row_above  [MAX_SIZE];
    bit [cdg_pkg::PIX_W-1:0]   row_two_up [MAX_SIZE];
    int unsigned               col_at = 0;
    int unsigned               row_at = 0;
    logic [cdg_pkg::CFG_W-1:0] width_setting  = cdg_pkg::CFG_W'(cdg_pkg::CFG_SIZE_RESET);
    logic [cdg_pkg::CFG_W-1:0] height_setting = cdg_pkg::CFG_W'(cdg_pkg::CFG_SIZE_RESET);

    gradient_t  pending_gradients [$];
    int         mismatch_count = 0;
    flow_mode_t flow = FLOW_FREE;
    int         hold_request = 0;
    int         hold_left = 0;

    central_difference_gradient uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pixel           (pixel),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .grad_horizontal (grad_horizontal),
        .grad_vertical   (grad_vertical),
        .last_in_run     (last_in_run),
        .end_of_image    (end_of_image)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Register values outside 1..MAX_SIZE act as the nearest legal size.
    function automatic int unsigned clamp_size(input logic [cdg_pkg::CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_SIZE)
            return MAX_SIZE;
        return v;
    endfunction

    // Work out the results caused by one accepted pixel and advance the line
    // buffers and position. A pixel in row j reports on the pixel one row up in
    // the same column; on the last row a zero result for the pixel itself follows.
    task automatic compute_gradients(input logic [cdg_pkg::PIX_W-1:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned i;
        int unsigned j;
        bit          end_row;
        bit          last_row;
        bit          interior;
        gradient_t   g;
        w = clamp_size(width_setting);
        h = clamp_size(height_setting);
        i = col_at;
        j = row_at;
        end_row  = (i + 1 >= w);
        last_row = (j + 1 >= h);
        if (j >= 1)
        begin
            g = '0;
            // The reported pixel sits in row j-1; it needs all four neighbors.
            interior = (i >= 1) && (i + 1 < w) && (j >= 2) && (j < h) && (i + 1 < MAX_SIZE);
            if (interior)
            begin
                // Right neighbor is still in row_above; the left one has already moved to row_two_up.
                g.horizontal = {1'b0, row_above[i + 1]} - {1'b0, row_two_up[i - 1]};
                g.vertical   = {1'b0, px} - {1'b0, row_two_up[i]};
            end
            // On the last row the trailing zero result closes the run instead.
            g.last = !last_row;
            g.eoi  = 1'b0;
            pending_gradients.push_back(g);
        end
        if (last_row)
        begin
            g = '0;
            g.last = 1'b1;
            g.eoi  = end_row;
            pending_gradients.push_back(g);
        end
        row_two_up[i] = row_above[i];
        row_above[i]  = px;
        if (end_row)
        begin
            col_at = 0;
            row_at = last_row ? 0 : j + 1;
        end
        else
        begin
            col_at = i + 1;
        end
    endtask

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endtask

    // Receiver: honor a long hold-off when one is requested, otherwise stall at
    // the rate of the current flow mode.
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            case (flow)
                FLOW_RECEIVER_STALL: out_stall <= ($urandom_range(99) < 85);
                FLOW_BOTH:           out_stall <= ($urandom_range(99) < 7);
                default:             out_stall <= 1'b0;
            endcase
        end
    end

    // Compare every output transfer with the oldest pending expectation.
    always @(posedge clk)
    begin
        gradient_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_gradients.size() == 0)
            begin
                note_mismatch($sformatf("unexpected result: h=%0d v=%0d last=%0b eoi=%0b",
                    grad_horizontal, grad_vertical, last_in_run, end_of_image));
            end
            else
            begin
                want = pending_gradients.pop_front();
                if (grad_horizontal !== want.horizontal || grad_vertical !== want.vertical ||
                    last_in_run !== want.last || end_of_image !== want.eoi)
                begin
                    note_mismatch($sformatf(
                    "want h=%0d v=%0d last=%0b eoi=%0b, got h=%0d v=%0d last=%0b eoi=%0b",
                    $signed(want.horizontal), $signed(want.vertical), want.last, want.eoi,
                    grad_horizontal, grad_vertical, last_in_run, end_of_image));
                end
            end
        end
    end

    // Offer one pixel, idling first as the flow mode asks, and hold it until the
    // transfer happens. Return at the edge of the transfer.
    task automatic send_pixel(input logic [cdg_pkg::PIX_W-1:0] px);
        int unsigned rest_pct;
        rest_pct = (flow == FLOW_SENDER_IDLE) ? 85 : (flow == FLOW_BOTH) ? 7 : 0;
        while ($urandom_range(99) < rest_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= px;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        compute_gradients(px);
    endtask

    // Mostly uniform pixels, with the two extremes weighted up.
    function automatic logic [cdg_pkg::PIX_W-1:0] random_pixel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return cdg_pkg::PIX_W'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random_pixels(input int count);
        repeat (count)
            send_pixel(random_pixel());
    endtask

    // Drop valid and wait until every expected result has arrived, then let the
    // pipeline settle in case the last pixel caused no result.
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (pending_gradients.size() != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);
    endtask

    // Write one register while the block is idle; any write restarts the image.
    task automatic write_reg(input logic [cdg_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned value);
        wait_results_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[cdg_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == cdg_pkg::REG_IMAGE_WIDTH)
            width_setting = value[cdg_pkg::CFG_W-1:0];
        else
            height_setting = value[cdg_pkg::CFG_W-1:0];
        col_at = 0;
        row_at = 0;
    endtask

    task automatic set_size(input int unsigned w, input int unsigned h);
        write_reg(cdg_pkg::REG_IMAGE_WIDTH, w);
        write_reg(cdg_pkg::REG_IMAGE_HEIGHT, h);
    endtask

    // Out of reset the image is 1024 x 1024; three first-row pixels give nothing.
    task automatic test_reset_size();
        flow = FLOW_FREE;
        send_random_pixels(3);
        wait_results_drained();
    endtask

    // Two 3x3 images back to back: both gradient extremes on the center pixel,
    // borders zero, and the position wraps into the second image.
    task automatic test_gradient_extremes();
        flow = FLOW_FREE;
        set_size(3, 3);
        foreach (RISING_3X3[k])
            send_pixel(RISING_3X3[k]);
        flow = FLOW_RECEIVER_STALL;
        foreach (FALLING_3X3[k])
            send_pixel(FALLING_3X3[k]);
    endtask

    // Zero sizes clamp to a single pixel; a single-row image gives one zero
    // result per pixel and flags the end on the last one.
    task automatic test_degenerate_sizes();
        flow = FLOW_BOTH;
        set_size(0, 0);
        send_random_pixels(2);
        set_size(4, 1);
        send_random_pixels(4);
    endtask

    // Largest sizes, written both exactly and from above the range; each image
    // is cut short and the next write restarts it.
    task automatic test_size_extremes();
        flow = FLOW_FREE;
        set_size(MAX_SIZE, 1);
        send_random_pixels(40);
        flow = FLOW_RECEIVER_STALL;
        set_size(2047, 1);
        send_random_pixels(40);
        flow = FLOW_SENDER_IDLE;
        set_size(1, MAX_SIZE);
        send_random_pixels(40);
        flow = FLOW_BOTH;
        set_size(0, 2047);
        send_random_pixels(40);
    endtask

    // Hold the receiver off long enough that the block fills and stalls its
    // input while pixels keep coming, then pause the sender mid-image.
    task automatic test_backpressure();
        flow = FLOW_FREE;
        set_size(8, 6);
        send_random_pixels(16);
        hold_request = HOLD_CYCLES;
        send_random_pixels(24);
        wait_results_drained();
        send_random_pixels(8);
    endtask

    // Random image sizes, mostly small with one to three whole images per setting,
    // now and then a single wide one; an image may be cut short or the sender
    // may pause to drain.
    task automatic test_random_images();
        int sent;
        int group;
        int w;
        int h;
        int count;
        int images;
        sent  = 0;
        group = 0;
        while (sent < RANDOM_ITEMS)
        begin
            flow = flow_mode_t'(group % 4);
            group++;
            if ($urandom_range(99) < 5)
            begin
                w = $urandom_range(64, 160);
                h = $urandom_range(1, 2);
                images = 1;
            end
            else
            begin
                w = $urandom_range(1, 16);
                h = $urandom_range(1, 8);
                images = $urandom_range(1, 3);
            end
            // Write a one-pixel dimension as zero now and then; it clamps to one.
            write_reg(cdg_pkg::REG_IMAGE_WIDTH, (w == 1 && $urandom_range(1)) ? 0 : w);
            write_reg(cdg_pkg::REG_IMAGE_HEIGHT, (h == 1 && $urandom_range(1)) ? 0 : h);
            repeat (images)
            begin
                if ($urandom_range(9) == 0)
                begin
                    count = $urandom_range(0, w * h - 1);
                    send_random_pixels(count);
                    sent += count;
                    break;
                end
                send_random_pixels(w * h);
                sent += w * h;
            end
            if ($urandom_range(3) == 0)
                wait_results_drained();
        end
    endtask

    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        test_reset_size();
        test_gradient_extremes();
        test_degenerate_sizes();
        test_size_extremes();
        test_backpressure();
        test_random_images();
        wait_results_drained();
        repeat (8)
            @(posedge clk);
        if (mismatch_count == 0 && pending_gradients.size() == 0)
            $display("tb_central_difference_gradient OK");
        else
            $display("tb_central_difference_gradient NOT OK");
        $finish;
    end

    // Hard stop for a hung handshake.
    initial
    begin
        #(LIMIT);
        $display("tb_central_difference_gradient NOT OK");
        $finish;
    end

endmodule
